/* design/block_edge_count_accumulator_unit_defines.svh */
// Assertion macros for the block edge count accumulator.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef BLOCK_EDGE_COUNT_ACCUMULATOR_UNIT_DEFINES_SVH
`define BLOCK_EDGE_COUNT_ACCUMULATOR_UNIT_DEFINES_SVH

// The condition implies the property in the same cycle.
`define BECA_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The condition implies the property in the following cycle.
`define BECA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* design/beca_pkg.sv */
package beca_pkg;

  // Widths fixed by the request and result formats.
  localparam int BLK_FIELD_W = 6;
  localparam int OUT_W       = 32;

  localparam logic [1:0] REQ_FLAG = 2'd0;
  localparam logic [1:0] REQ_EDGE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [BLK_FIELD_W-1:0] block_a;
    logic [BLK_FIELD_W-1:0] block_b;
    logic                   flag_value;
  } in_req_t;

  typedef struct packed {
    logic             edge_counted;
    logic [OUT_W-1:0] pair_count;
    logic [OUT_W-1:0] out_degree;
    logic [OUT_W-1:0] in_degree;
    logic [OUT_W-1:0] total_degree;
  } out_res_t;

endpackage

/* design/beca_fwd_ram.sv */
module beca_fwd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;
  logic [WIDTH-1:0] byp_data_r;
  logic             byp_r;

  // A read that meets a write to the same entry at the same edge would see
  // the old contents, so the written word is captured and takes its place.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r       <= mem[raddr];
      byp_r      <= we && (waddr == raddr);
      byp_data_r <= wdata;
    end
  end

  assign rdata = byp_r ? byp_data_r : rd_r;

endmodule

/* design/block_edge_count_accumulator_unit.sv */
// Channel   Direction  Handshake            Payload
// in_*      input      in_valid / in_stall   beca_pkg::in_req_t
// out_*     output     out_valid / out_stall beca_pkg::out_res_t
// cfg_*     input      cfg_we                cfg_wdata (undirected mode)
//
// One request per cycle while in_stall is low; its result passes the read and
// write back, total degree and output register stages. A write to the
// entry that the next request reads is forwarded around the memory read.
// After reset a clearing pass walks all 2^(2*ceil(log2 BLOCK_COUNT)) entries
// of the pair count memory (4096 at the default) with in_stall high.
// A stalled valid result holds the whole pipeline and raises in_stall.
`include "block_edge_count_accumulator_unit_defines.svh"

module block_edge_count_accumulator_unit #(
  parameter int BLOCK_COUNT = 64,
  parameter int COUNT_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  beca_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output beca_pkg::out_res_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  import beca_pkg::*;

  localparam int BLK_W      = $clog2(BLOCK_COUNT);
  localparam int EXT_W      = ((BLK_W > BLK_FIELD_W) ? BLK_W : BLK_FIELD_W) + 1;
  localparam int PAIR_AW    = 2 * BLK_W;
  localparam int BLK_DEPTH  = 1 << BLK_W;
  localparam int PAIR_DEPTH = 1 << PAIR_AW;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // Control
  logic               clear_r;
  logic [PAIR_AW-1:0] clr_cnt_r;
  logic               undirected_r;
  logic               adv;
  logic               accept;

  // Request decode
  logic [EXT_W-1:0] a_ext;
  logic [EXT_W-1:0] b_ext;
  logic             a_ok;
  logic             b_ok;
  logic [BLK_W-1:0] a_idx;
  logic [BLK_W-1:0] b_idx;

  // Read and update stage
  logic             s1_valid_r;
  logic [1:0]       s1_req_r;
  logic [BLK_W-1:0] s1_a_r;
  logic [BLK_W-1:0] s1_b_r;
  logic             s1_aok_r;
  logic             s1_bok_r;
  logic             s1_fv_r;

  logic fa_rd;
  logic fb_rd;
  cnt_t pair_rd;
  cnt_t out_rd;
  cnt_t ina_rd;
  cnt_t inb_rd;

  logic is_edge;
  logic is_read;
  logic report;
  logic do_count;
  logic upd;
  cnt_t pair_n;
  cnt_t out_n;
  cnt_t inb_n;
  cnt_t ina_n;

  // Memory write ports
  logic               flag_we;
  logic [BLK_W-1:0]   flag_waddr;
  logic               flag_wdata;
  logic               pair_we;
  logic [PAIR_AW-1:0] pair_waddr;
  cnt_t               pair_wdata;
  logic               deg_we;
  logic [BLK_W-1:0]   out_waddr;
  logic [BLK_W-1:0]   in_waddr;
  cnt_t               out_wdata;
  cnt_t               in_wdata;

  // Total degree stage
  logic s2_valid_r;
  logic s2_counted_r;
  cnt_t s2_pair_r;
  cnt_t s2_out_r;
  cnt_t s2_in_r;
  cnt_t s2_ina_r;

  logic [COUNT_BITS:0] tot_sum;
  cnt_t                tot;

  logic     out_valid_r;
  out_res_t out_data_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = clear_r || !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_ext = EXT_W'(in_data.block_a);
    b_ext = EXT_W'(in_data.block_b);
    a_ok  = a_ext < EXT_W'(BLOCK_COUNT);
    b_ok  = b_ext < EXT_W'(BLOCK_COUNT);
    a_idx = a_ext[BLK_W-1:0];
    b_idx = b_ext[BLK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + PAIR_AW'(1);
      if (clr_cnt_r == '1) begin
        clear_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undirected_r <= 1'b0;
    end else if (cfg_we) begin
      undirected_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r <= in_data.req_type;
      s1_a_r   <= a_idx;
      s1_b_r   <= b_idx;
      s1_aok_r <= a_ok;
      s1_bok_r <= b_ok;
      s1_fv_r  <= in_data.flag_value;
    end
  end

  always_comb begin
    is_edge  = (s1_req_r == REQ_EDGE) && s1_aok_r && s1_bok_r;
    is_read  = (s1_req_r == REQ_READ) && s1_aok_r && s1_bok_r;
    report   = is_edge || is_read;
    do_count = is_edge && fa_rd && fb_rd;
    upd      = s1_valid_r && adv;
    pair_n   = do_count ? sat_inc(pair_rd) : pair_rd;
    out_n    = do_count ? sat_inc(out_rd) : out_rd;
    inb_n    = do_count ? sat_inc(inb_rd) : inb_rd;
    // A self edge also raises the in degree of the source block.
    ina_n    = (do_count && (s1_a_r == s1_b_r)) ? inb_n : ina_rd;
  end

  // The clearing pass shares the write ports; small memories are swept
  // repeatedly through the low address bits.
  always_comb begin
    flag_we    = clear_r || (upd && (s1_req_r == REQ_FLAG) && s1_aok_r);
    flag_waddr = clear_r ? clr_cnt_r[BLK_W-1:0] : s1_a_r;
    flag_wdata = clear_r ? 1'b0 : s1_fv_r;
    pair_we    = clear_r || (upd && do_count);
    pair_waddr = clear_r ? clr_cnt_r : {s1_a_r, s1_b_r};
    pair_wdata = clear_r ? '0 : pair_n;
    deg_we     = clear_r || (upd && do_count);
    out_waddr  = clear_r ? clr_cnt_r[BLK_W-1:0] : s1_a_r;
    in_waddr   = clear_r ? clr_cnt_r[BLK_W-1:0] : s1_b_r;
    out_wdata  = clear_r ? '0 : out_n;
    in_wdata   = clear_r ? '0 : inb_n;
  end

  beca_fwd_ram #(.DEPTH(BLK_DEPTH), .WIDTH(1)) u_flag_a_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (adv),
    .raddr (a_idx),
    .rdata (fa_rd)
  );

  beca_fwd_ram #(.DEPTH(BLK_DEPTH), .WIDTH(1)) u_flag_b_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (adv),
    .raddr (b_idx),
    .rdata (fb_rd)
  );

  beca_fwd_ram #(.DEPTH(PAIR_DEPTH), .WIDTH(COUNT_BITS)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (adv),
    .raddr ({a_idx, b_idx}),
    .rdata (pair_rd)
  );

  beca_fwd_ram #(.DEPTH(BLK_DEPTH), .WIDTH(COUNT_BITS)) u_out_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .re    (adv),
    .raddr (a_idx),
    .rdata (out_rd)
  );

  // The in degree memory is kept twice so that rows a and b read together.
  beca_fwd_ram #(.DEPTH(BLK_DEPTH), .WIDTH(COUNT_BITS)) u_in_a_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (adv),
    .raddr (a_idx),
    .rdata (ina_rd)
  );

  beca_fwd_ram #(.DEPTH(BLK_DEPTH), .WIDTH(COUNT_BITS)) u_in_b_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .re    (adv),
    .raddr (b_idx),
    .rdata (inb_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Requests that report nothing carry zeros from here on.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_counted_r <= do_count;
      s2_pair_r    <= report ? pair_n : '0;
      s2_out_r     <= report ? out_n : '0;
      s2_in_r      <= is_edge ? inb_n : (is_read ? ina_rd : '0);
      s2_ina_r     <= report ? ina_n : '0;
    end
  end

  always_comb begin
    tot_sum = {1'b0, s2_out_r} + {1'b0, s2_ina_r};
    if (undirected_r) begin
      tot = s2_out_r;
    end else begin
      tot = tot_sum[COUNT_BITS] ? '1 : tot_sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.edge_counted <= s2_counted_r;
      out_data_r.pair_count   <= OUT_W'(s2_pair_r);
      out_data_r.out_degree   <= OUT_W'(s2_out_r);
      out_data_r.in_degree    <= OUT_W'(s2_in_r);
      out_data_r.total_degree <= OUT_W'(tot);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BECA_ASSERT_SAME(a_counted_nonzero, s2_valid_r && s2_counted_r, s2_out_r != '0, "counted edge left a zero out degree")
  `BECA_ASSERT_SAME(a_empty_in_clear, clear_r, !out_valid_r && !s1_valid_r && !s2_valid_r, "request in flight during the clearing pass")
  `BECA_ASSERT_NEXT(a_hold_on_stall, out_valid_r && out_stall, $stable(s1_valid_r) && $stable(s2_valid_r), "pipeline moved under a stalled result")

endmodule

/* dv/edge_count_checker.sv */
`timescale 1ns / 1ps

module edge_count_checker
  import beca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_res_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output int       fail_count,
  output int       req_seen,
  output int       res_seen,
  output int       edges_counted
);

  localparam int NBLK      = 64;
  localparam int MAX_SHOWN = 40;

  logic             stored   [NBLK];
  logic [OUT_W-1:0] pair_cnt [NBLK*NBLK];
  logic [OUT_W-1:0] out_deg  [NBLK];
  logic [OUT_W-1:0] in_deg   [NBLK];
  logic             undirected;
  out_res_t         pending_results[$];
  int               shown;

  function automatic logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] total_of(logic [BLK_FIELD_W-1:0] blk);
    logic [OUT_W:0] sum;
    if (undirected) begin
      return out_deg[blk];
    end
    sum = {1'b0, out_deg[blk]} + {1'b0, in_deg[blk]};
    return sum[OUT_W] ? '1 : sum[OUT_W-1:0];
  endfunction

  // Block fields are six bits wide, so every block number is in range here.
  function automatic out_res_t apply_request(in_req_t r);
    out_res_t                   res;
    logic [2*BLK_FIELD_W-1:0]   slot;
    res  = '0;
    slot = {r.block_a, r.block_b};
    case (r.req_type)
      REQ_FLAG: begin
        stored[r.block_a] = r.flag_value;
      end
      REQ_EDGE: begin
        if (stored[r.block_a] && stored[r.block_b]) begin
          pair_cnt[slot]     = bump(pair_cnt[slot]);
          out_deg[r.block_a] = bump(out_deg[r.block_a]);
          in_deg[r.block_b]  = bump(in_deg[r.block_b]);
          res.edge_counted   = 1'b1;
        end
        res.pair_count   = pair_cnt[slot];
        res.out_degree   = out_deg[r.block_a];
        res.in_degree    = in_deg[r.block_b];
        res.total_degree = total_of(r.block_a);
      end
      REQ_READ: begin
        res.pair_count   = pair_cnt[slot];
        res.out_degree   = out_deg[r.block_a];
        res.in_degree    = in_deg[r.block_a];
        res.total_degree = total_of(r.block_a);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int field_diff(string fname, logic [OUT_W-1:0] want,
                                    logic [OUT_W-1:0] got);
    if (want === got) begin
      return 0;
    end
    if (shown < MAX_SHOWN) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
    shown++;
    return 1;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < NBLK; i++) begin
        stored[i]  = 1'b0;
        out_deg[i] = '0;
        in_deg[i]  = '0;
      end
      for (int i = 0; i < NBLK*NBLK; i++) begin
        pair_cnt[i] = '0;
      end
      undirected = 1'b0;
      pending_results.delete();
      shown         = 0;
      fail_count    <= 0;
      req_seen      <= 0;
      res_seen      <= 0;
      edges_counted <= 0;
    end else begin
      if (cfg_we) begin
        undirected = cfg_wdata;
      end
      // Results are taken before the new request is predicted, so a result in
      // the same cycle can never be matched against its own request.
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (shown < MAX_SHOWN) begin
            $display("%0t: result with nothing expected, got %p", $time, out_data);
          end
          shown++;
          errs++;
        end else begin
          want = pending_results.pop_front();
          errs += field_diff("edge_counted", want.edge_counted, out_data.edge_counted);
          errs += field_diff("pair_count", want.pair_count, out_data.pair_count);
          errs += field_diff("out_degree", want.out_degree, out_data.out_degree);
          errs += field_diff("in_degree", want.in_degree, out_data.in_degree);
          errs += field_diff("total_degree", want.total_degree, out_data.total_degree);
        end
        res_seen <= res_seen + 1;
      end
      if (in_valid && !in_stall) begin
        want = apply_request(in_data);
        pending_results.insert(pending_results.size(), want);
        req_seen <= req_seen + 1;
        if (want.edge_counted) begin
          edges_counted <= edges_counted + 1;
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* dv/block_edge_count_accumulator_unit_tb.sv */
`timescale 1ns / 1ps

module block_edge_count_accumulator_unit_tb;
  import beca_pkg::*;

  localparam logic [1:0] REQ_UNUSED      = 2'd3;
  localparam logic       MODE_DIRECTED   = 1'b0;
  localparam logic       MODE_UNDIRECTED = 1'b1;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         HOLD_CYCLES     = 80;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         PHASES          = 6;
  localparam int         PHASE_ITEMS     = 220;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_res_t out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  int fail_count;
  int req_seen;
  int res_seen;
  int edges_counted;
  int cycles;
  int n_flag;
  int n_edge;
  int n_read;
  int n_unused;
  int n_mode_writes;
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold;

  block_edge_count_accumulator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  edge_count_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .req_seen      (req_seen),
    .res_seen      (res_seen),
    .edges_counted (edges_counted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: a random stall before each result while rx_idle_on is set, and
  // one long hold-off on request from the stimulus so that the pipeline fills up.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic in_req_t req_of(logic [1:0] kind, logic [5:0] a, logic [5:0] b,
                                     logic f);
    in_req_t r;
    r.req_type   = kind;
    r.block_a    = a;
    r.block_b    = b;
    r.flag_value = f;
    return r;
  endfunction

  // Most traffic lands on a few hot blocks so that edges get counted and the
  // same count entries are hit back to back.
  function automatic logic [5:0] pick_block();
    int k;
    if ($urandom_range(0, 3) == 0) begin
      return 6'($urandom_range(0, 63));
    end
    k = $urandom_range(0, 7);
    return (k < 4) ? 6'(k) : 6'(56 + k);
  endfunction

  function automatic in_req_t random_req();
    int       roll;
    in_req_t  r;
    roll = $urandom_range(0, 99);
    r = req_of(REQ_EDGE, pick_block(), pick_block(), 1'($urandom_range(0, 1)));
    if (roll < 15) begin
      r.req_type   = REQ_FLAG;
      r.flag_value = ($urandom_range(0, 3) != 0);
    end else if (roll < 70) begin
      r.req_type = REQ_EDGE;
    end else if (roll < 95) begin
      r.req_type = REQ_READ;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send_req(input in_req_t r);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    case (r.req_type)
      REQ_FLAG: n_flag++;
      REQ_EDGE: n_edge++;
      REQ_READ: n_read++;
      default:  n_unused++;
    endcase
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (req_seen != res_seen) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    n_mode_writes++;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    cycles    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The count memory is cleared after reset while the input is stalled.
    @(posedge clk);
    while (in_stall) @(posedge clk);
    set_mode(MODE_DIRECTED);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    send_req(req_of(REQ_READ, 6'd0, 6'd0, 1'b0));
    send_req(req_of(REQ_READ, 6'd63, 6'd63, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd63, 1'b0));
    send_req(req_of(REQ_FLAG, 6'd0, 6'd63, 1'b1));
    send_req(req_of(REQ_FLAG, 6'd63, 6'd0, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd63, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd63, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd63, 6'd0, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd0, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd0, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd63, 6'd63, 1'b0));
    send_req(req_of(REQ_READ, 6'd0, 6'd63, 1'b0));
    send_req(req_of(REQ_READ, 6'd63, 6'd0, 1'b0));
    send_req(req_of(REQ_FLAG, 6'd63, 6'd63, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd63, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd63, 6'd63, 1'b1));
    send_req(req_of(REQ_UNUSED, 6'd63, 6'd63, 1'b1));
    send_req(req_of(REQ_FLAG, 6'd21, 6'd42, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd21, 6'd42, 1'b0));
    send_req(req_of(REQ_FLAG, 6'd42, 6'd21, 1'b1));
    send_req(req_of(REQ_EDGE, 6'd42, 6'd21, 1'b1));
    send_req(req_of(REQ_READ, 6'd42, 6'd42, 1'b0));
    wait_drained();

    set_mode(MODE_UNDIRECTED);
    send_req(req_of(REQ_READ, 6'd0, 6'd63, 1'b0));
    send_req(req_of(REQ_EDGE, 6'd0, 6'd0, 1'b0));
    send_req(req_of(REQ_READ, 6'd42, 6'd21, 1'b1));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(ph[0] ? MODE_DIRECTED : MODE_UNDIRECTED);
      tx_idle_on = (ph != 2) && (ph != 4);
      rx_idle_on = (ph != 3);
      // One phase sends back to back into a long result stall.
      if (ph == 4) begin
        long_hold = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_req(random_req());
      end
      wait_drained();
    end

    $display("Sent %0d requests: %0d flag, %0d edge (%0d counted), %0d read, %0d unused.",
             req_seen, n_flag, n_edge, edges_counted, n_read, n_unused);
    $display("Checked %0d results over %0d mode writes in both modes.",
             res_seen, n_mode_writes);
    if (fail_count == 0 && req_seen == res_seen) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d requests, %0d results.", fail_count, req_seen, res_seen);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
